// ----- rtl/mpp_pkg.sv -----
package mpp_pkg;

    localparam int COORD_W             = 64;
    localparam int COORD_FRAC_BITS_DEF = 40;
    localparam int COUNT_W             = 18;
    localparam int LOG_W               = 32;
    localparam int PROD_W              = 2 * COORD_W;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(65536);
    localparam logic [31:0]        ESCAPE_LIMIT   = 32'd1000000;
    // round(0.5*ln(2)*2^32)
    localparam logic [31:0]        HALF_LN2_Q32   = 32'd1488522236;

    typedef struct packed {
        logic                escaped;
        logic [COUNT_W-1:0]  iteration_count;
        logic [LOG_W-1:0]    half_log_radius;
    } res_t;

endpackage

// ----- rtl/mpp_mul64.sv -----
// 64x64 unsigned multiply on one 32x32 multiplier, one partial product per cycle.
module mpp_mul64 (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mpp_pkg::COORD_W-1:0] a,
    input  logic [mpp_pkg::COORD_W-1:0] b,
    output logic                       done,
    output logic [mpp_pkg::PROD_W-1:0] product
);
    import mpp_pkg::*;

    logic                busy_reg, busy_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [1:0]          sel_reg, sel_next;
    logic [63:0]         pp_reg, pp_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [31:0]         a_half, b_half;
    logic [PROD_W-1:0]   pp_shifted;

    assign a_half = cnt_reg[0] ? a[63:32] : a[31:0];
    assign b_half = cnt_reg[1] ? b[63:32] : b[31:0];

    always_comb begin
        case (sel_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        sel_next  = cnt_reg[1:0];
        pp_next   = pp_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            acc_next  = '0;
        end else if (busy_reg) begin
            pp_next  = {32'd0, a_half} * {32'd0, b_half};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg != 3'd0) begin
                acc_next = acc_reg + pp_shifted;
            end
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        sel_reg <= sel_next;
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/mpp_core.sv -----
module mpp_core #(
    parameter int COORD_FRAC_BITS = mpp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mpp_pkg::COORD_W-1:0] c_real,
    input  logic [mpp_pkg::COORD_W-1:0] c_imag,
    input  logic [mpp_pkg::COUNT_W-1:0] max_iterations,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mpp_pkg::res_t               res
);
    import mpp_pkg::*;

    localparam int TWO_F = 2 * COORD_FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_CHK, S_MXY, S_UPD1, S_UPD2,
        S_NORM, S_SQM, S_LMUL, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [63:0]         cr_reg, cr_next, ci_reg, ci_next;
    logic [63:0]         x_reg, x_next, y_reg, y_next;
    logic [COUNT_W-1:0]  iter_reg, iter_next;
    logic [PROD_W-1:0]   x2_reg, x2_next, y2_reg, y2_next, xy_reg, xy_next;
    logic                xy_neg_reg, xy_neg_next;
    logic signed [PROD_W:0] d_reg, d_next, xs_reg, xs_next;
    logic [PROD_W-1:0]   nrm_reg, nrm_next;
    logic [6:0]          e_reg, e_next;
    logic [63:0]         m_reg, m_next;
    logic [31:0]         frac_reg, frac_next;
    logic [4:0]          k_reg, k_next;
    logic [63:0]         op_a_reg, op_a_next, op_b_reg, op_b_next;
    logic                mstart_reg, mstart_next;
    res_t                res_reg, res_next;

    logic                mul_done;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]   s_sum, s_int;
    logic                esc;
    logic [63:0]         ax, ay, lq, ev;
    logic signed [PROD_W:0] nx_w, ny_w;
    logic [63:0]         nx_sat, ny_sat;
    logic [31:0]         hl;

    mpp_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mstart_reg),
        .a       (op_a_reg),
        .b       (op_b_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    function automatic logic [63:0] sat64(input logic signed [PROD_W:0] v);
        logic [PROD_W-63:0] top;
        logic [63:0]        r;
        top = v[PROD_W:63];
        if ((&top) || !(|top)) begin
            r = v[63:0];
        end else begin
            r = v[PROD_W] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    assign ax     = x_reg[63] ? 64'(-x_reg) : x_reg;
    assign ay     = y_reg[63] ? 64'(-y_reg) : y_reg;
    assign s_sum  = x2_reg + y2_reg;
    assign s_int  = s_sum >> TWO_F;
    assign esc    = s_int >= PROD_W'(ESCAPE_LIMIT);
    assign nx_w   = (d_reg >>> COORD_FRAC_BITS)
                    + $signed({{(PROD_W-63){cr_reg[63]}}, cr_reg});
    assign ny_w   = (xs_reg >>> (COORD_FRAC_BITS - 1))
                    + $signed({{(PROD_W-63){ci_reg[63]}}, ci_reg});
    assign nx_sat = sat64(nx_w);
    assign ny_sat = sat64(ny_w);
    assign ev     = 64'(e_reg) - 64'(TWO_F);
    assign lq     = (ev << 32) | {32'd0, frac_next};
    assign hl     = (|mul_p[PROD_W-1:72]) ? 32'hFFFF_FFFF : mul_p[71:40];

    always_comb begin
        state_next  = state_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        iter_next   = iter_reg;
        x2_next     = x2_reg;
        y2_next     = y2_reg;
        xy_next     = xy_reg;
        xy_neg_next = xy_neg_reg;
        d_next      = d_reg;
        xs_next     = xs_reg;
        nrm_next    = nrm_reg;
        e_next      = e_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        k_next      = k_reg;
        op_a_next   = op_a_reg;
        op_b_next   = op_b_reg;
        mstart_next = 1'b0;
        res_next    = res_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    cr_next     = c_real;
                    ci_next     = c_imag;
                    x_next      = c_real;
                    y_next      = c_imag;
                    iter_next   = '0;
                    op_a_next   = c_real[63] ? 64'(-c_real) : c_real;
                    op_b_next   = c_real[63] ? 64'(-c_real) : c_real;
                    mstart_next = 1'b1;
                    state_next  = S_SQX;
                end
            end
            S_SQX: begin
                if (mul_done) begin
                    x2_next     = mul_p;
                    op_a_next   = ay;
                    op_b_next   = ay;
                    mstart_next = 1'b1;
                    state_next  = S_SQY;
                end
            end
            S_SQY: begin
                if (mul_done) begin
                    y2_next    = mul_p;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (iter_reg >= max_iterations) begin
                    res_next   = '{escaped: 1'b0, iteration_count: iter_reg,
                                   half_log_radius: '0};
                    state_next = S_DONE;
                end else if (esc) begin
                    nrm_next   = s_sum;
                    e_next     = 7'd127;
                    state_next = S_NORM;
                end else begin
                    op_a_next   = ax;
                    op_b_next   = ay;
                    xy_neg_next = x_reg[63] ^ y_reg[63];
                    mstart_next = 1'b1;
                    state_next  = S_MXY;
                end
            end
            S_MXY: begin
                if (mul_done) begin
                    xy_next    = mul_p;
                    state_next = S_UPD1;
                end
            end
            S_UPD1: begin
                d_next     = $signed({1'b0, x2_reg}) - $signed({1'b0, y2_reg});
                xs_next    = xy_neg_reg ? -$signed({1'b0, xy_reg}) : $signed({1'b0, xy_reg});
                state_next = S_UPD2;
            end
            S_UPD2: begin
                x_next      = nx_sat;
                y_next      = ny_sat;
                iter_next   = iter_reg + COUNT_W'(1);
                op_a_next   = nx_sat[63] ? 64'(-nx_sat) : nx_sat;
                op_b_next   = nx_sat[63] ? 64'(-nx_sat) : nx_sat;
                mstart_next = 1'b1;
                state_next  = S_SQX;
            end
            S_NORM: begin
                // escaped, so s is nonzero and this stops
                if (nrm_reg[PROD_W-1]) begin
                    m_next      = nrm_reg[PROD_W-1:64];
                    frac_next   = '0;
                    k_next      = '0;
                    op_a_next   = nrm_reg[PROD_W-1:64];
                    op_b_next   = nrm_reg[PROD_W-1:64];
                    mstart_next = 1'b1;
                    state_next  = S_SQM;
                end else begin
                    nrm_next = nrm_reg << 1;
                    e_next   = e_reg - 7'd1;
                end
            end
            S_SQM: begin
                if (mul_done) begin
                    frac_next = {frac_reg[30:0], mul_p[PROD_W-1]};
                    m_next    = mul_p[PROD_W-1] ? mul_p[PROD_W-1:64] : mul_p[PROD_W-2:63];
                    k_next    = k_reg + 5'd1;
                    mstart_next = 1'b1;
                    if (k_reg == 5'd31) begin
                        op_a_next  = lq;
                        op_b_next  = {32'd0, HALF_LN2_Q32};
                        state_next = S_LMUL;
                    end else begin
                        op_a_next = m_next;
                        op_b_next = m_next;
                    end
                end
            end
            S_LMUL: begin
                if (mul_done) begin
                    res_next   = '{escaped: 1'b1, iteration_count: iter_reg,
                                   half_log_radius: hl};
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mstart_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mstart_reg <= mstart_next;
        end
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        iter_reg   <= iter_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        xy_reg     <= xy_next;
        xy_neg_reg <= xy_neg_next;
        d_reg      <= d_next;
        xs_reg     <= xs_next;
        nrm_reg    <= nrm_next;
        e_reg      <= e_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        k_reg      <= k_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        res_reg    <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

// ----- rtl/mandelbrot_potential_pixel_top.sv -----
// Escape-time Mandelbrot pixel with continuous potential.
// Input channel (s_*): one transaction carries a point c, Q24.40 real and
// imaginary parts. Result channel (m_*): escape flag, iteration count and
// 0.5*ln(|z|^2) in unsigned Q8.24 (zero when the point did not escape).
// cfg_wr_en/cfg_wr_data write the dwell limit; write only while idle.
// All multiplications run on one 32x32 multiplier. One iteration takes three
// products plus three control states, and an escaped point adds a normalize
// loop, 32 squarings and one more product for the log.
// s_tready is high only while no point is in flight.
// The result sits in an output register; a stalled receiver holds it and
// the block still takes the next point, finishing it only once the
// register frees up. Reset clears all control and sets the dwell limit
// to 65536.
module mandelbrot_potential_pixel_top #(
    parameter int COORD_FRAC_BITS = mpp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [127:0]                s_tdata,    // c_real, c_imag
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [55:0]                 m_tdata,    // escaped, iteration_count, half_log_radius
    input  logic                        cfg_wr_en,
    input  logic [mpp_pkg::COUNT_W-1:0] cfg_wr_data
);
    import mpp_pkg::*;

    logic [COUNT_W-1:0] max_iter_reg;
    logic               m_valid_reg;
    res_t               m_res_reg;
    logic               core_idle, res_valid, res_ready;
    res_t               core_res;

    mpp_core #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (s_tvalid && s_tready),
        .c_real         (s_tdata[63:0]),
        .c_imag         (s_tdata[127:64]),
        .max_iterations (max_iter_reg),
        .idle           (core_idle),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (core_res)
    );

    assign s_tready  = core_idle;
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= MAX_ITER_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_iter_reg <= cfg_wr_data;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
        if (res_ready && res_valid) begin
            m_res_reg <= core_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.half_log_radius, m_res_reg.iteration_count,
                       m_res_reg.escaped};

endmodule

// ----- rtl/mpp_checker.sv -----
module mpp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_inside_no_log: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[50:19] == 32'd0)
        else $error("log nonzero for a point that did not escape");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accepting a point");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind mandelbrot_potential_pixel_top mpp_checker u_mpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
